>>> sv/seven_segment_number_display_defines.svh
// Assertion macros shared by the display driver RTL.
`ifndef SEVEN_SEGMENT_NUMBER_DISPLAY_DEFINES_SVH
`define SEVEN_SEGMENT_NUMBER_DISPLAY_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSND_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("display driver check failed");

// next-cycle implication, sampled on clk, off during reset
`define SSND_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("display driver check failed");

`endif

>>> sv/ssnd_pkg.sv
package ssnd_pkg;

  localparam int DISPLAY_COUNT = 6;
  // slots that physically exist in the two words
  localparam int SLOT_CAP = 6;
  // digit loop never runs past this slot count
  localparam int DIGIT_LIMIT = 8;

  localparam int NUM_W = 21;
  localparam int SLOT_W = 4;
  localparam int SEGS_W = 8 * SLOT_CAP;

  localparam logic [7:0] SEG_KEEP = 8'h80;  // clear digit keeps bit 7 only
  localparam logic [6:0] SEG_MINUS = 7'h40;
  localparam logic [7:0] SEG_ZERO = 8'h3F;

  // x / 10 as (x * RECIP10) >> RECIP_SHIFT, exact for x below 2**22
  localparam int RECIP_W = 20;
  localparam int RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP10 = 20'd838861;

  typedef enum logic [1:0] {
    CMD_CLEAR_ALL   = 2'd0,
    CMD_CLEAR_DIGIT = 2'd1,
    CMD_WRITE_HEX   = 2'd2,
    CMD_NUMBER      = 2'd3
  } cmd_t;

  function automatic logic [6:0] hex_seg(input logic [3:0] v);
    logic [6:0] s;
    case (v)
      4'h0: s = 7'h3F;
      4'h1: s = 7'h06;
      4'h2: s = 7'h5B;
      4'h3: s = 7'h4F;
      4'h4: s = 7'h66;
      4'h5: s = 7'h6D;
      4'h6: s = 7'h7D;
      4'h7: s = 7'h07;
      4'h8: s = 7'h7F;
      4'h9: s = 7'h6F;
      4'hA: s = 7'h77;
      4'hB: s = 7'h7C;
      4'hC: s = 7'h39;
      4'hD: s = 7'h5E;
      4'hE: s = 7'h79;
      4'hF: s = 7'h71;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic logic slot_ok(input logic [SLOT_W-1:0] slot);
    return (slot < SLOT_W'(DISPLAY_COUNT)) && (slot < SLOT_W'(SLOT_CAP));
  endfunction

  // OR a segment code into one slot; out-of-range slots are ignored
  function automatic logic [SEGS_W-1:0] slot_or(input logic [SEGS_W-1:0] segs,
                                                input logic [SLOT_W-1:0] slot,
                                                input logic [6:0] code);
    logic [SEGS_W-1:0] r;
    r = segs;
    if (slot_ok(slot)) begin
      r[8*slot[2:0] +: 8] = segs[8*slot[2:0] +: 8] | {1'b0, code};
    end
    return r;
  endfunction

endpackage

>>> sv/seven_segment_number_display.sv
// Channel  | signals                                       | handshake
// ---------+-----------------------------------------------+------------------------
// request  | mode, digit_position, digit_value, number     | start && !busy
// result   | low_displays, high_displays, overflow          | done, one cycle
//
// Clear all, clear digit and write hex raise done in the cycle after acceptance.
// Show number converts one decimal digit per cycle with a shared divide-by-10
// (reciprocal multiply) for 1..7 digits, then adds a minus sign if negative.
// busy is high only during show number, until done; done may coincide with acceptance.
// Synchronous reset loads the zero code into all six slots and clears done.
// The result is shown for exactly one cycle; the receiver cannot stall it.
`include "seven_segment_number_display_defines.svh"

module seven_segment_number_display (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode,
  input  logic [2:0]                   digit_position,
  input  logic [3:0]                   digit_value,
  input  logic signed [ssnd_pkg::NUM_W-1:0] number,
  output logic                         done,
  output logic [31:0]                  low_displays,
  output logic [15:0]                  high_displays,
  output logic                         overflow
);
  import ssnd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIGIT = 3'b010,
    ST_SIGN  = 3'b100
  } state_t;

  state_t                state, state_next;
  logic [SEGS_W-1:0]     segs, segs_next;
  logic [NUM_W-1:0]      mag, mag_next;
  logic [SLOT_W-1:0]     slot, slot_next;
  logic                  neg, neg_next;
  logic                  ovf, ovf_next;
  logic                  done_next;

  logic                  accept;
  cmd_t                  cmd;
  logic [NUM_W+RECIP_W-1:0] prod;
  logic [NUM_W-1:0]      quot;
  logic [NUM_W-1:0]      quot10;
  logic [NUM_W-1:0]      rem_full;
  logic [3:0]            rem;
  logic [SLOT_W-1:0]     slot_inc;
  logic [SLOT_W-1:0]     pos_ext;

  assign accept = start && !busy;
  assign cmd = cmd_t'(mode);
  assign busy = (state != ST_IDLE);
  assign pos_ext = SLOT_W'(digit_position);

  // shared divide-by-10 unit
  assign prod = NUM_W'(mag) * RECIP10;
  assign quot = NUM_W'(prod >> RECIP_SHIFT);
  assign quot10 = NUM_W'({quot, 3'b000}) + NUM_W'({quot, 1'b0});
  assign rem_full = mag - quot10;
  assign rem = rem_full[3:0];
  assign slot_inc = slot + SLOT_W'(1);

  always_comb begin
    state_next = state;
    segs_next = segs;
    mag_next = mag;
    slot_next = slot;
    neg_next = neg;
    ovf_next = ovf;
    done_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ovf_next = 1'b0;
          case (cmd)
            CMD_CLEAR_ALL: begin
              segs_next = '0;
              done_next = 1'b1;
            end
            CMD_CLEAR_DIGIT: begin
              if (slot_ok(pos_ext)) begin
                segs_next[8*digit_position +: 8] = segs[8*digit_position +: 8] & SEG_KEEP;
              end
              done_next = 1'b1;
            end
            CMD_WRITE_HEX: begin
              segs_next = slot_or(segs, pos_ext, hex_seg(digit_value));
              done_next = 1'b1;
            end
            CMD_NUMBER: begin
              segs_next = '0;
              neg_next = number[NUM_W-1];
              mag_next = number[NUM_W-1] ? (NUM_W'(0) - NUM_W'(number)) : NUM_W'(number);
              slot_next = '0;
              state_next = ST_DIGIT;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_DIGIT: begin
        segs_next = slot_or(segs, slot, hex_seg(rem));
        mag_next = quot;
        slot_next = slot_inc;
        if (quot == '0 || slot_inc == SLOT_W'(DIGIT_LIMIT)) begin
          if (neg) begin
            state_next = ST_SIGN;
          end else begin
            ovf_next = (slot_inc > SLOT_W'(DISPLAY_COUNT));
            done_next = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_SIGN: begin
        segs_next = slot_or(segs, slot, SEG_MINUS);
        slot_next = slot_inc;
        ovf_next = (slot_inc > SLOT_W'(DISPLAY_COUNT));
        done_next = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      segs <= {SLOT_CAP{SEG_ZERO}};
      ovf <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      segs <= segs_next;
      ovf <= ovf_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    mag <= mag_next;
    slot <= slot_next;
    neg <= neg_next;
  end

  assign low_displays = segs[31:0];
  assign high_displays = segs[47:32];
  assign overflow = ovf;

  `SSND_ASSERT_NOW(a_done_idle, done, state == ST_IDLE)
  `SSND_ASSERT_NEXT(a_short_cmd, accept && cmd != CMD_NUMBER, done)
  `SSND_ASSERT_NEXT(a_number_busy, accept && cmd == CMD_NUMBER, busy && !done)
  `SSND_ASSERT_NOW(a_no_bit7, 1'b1,
                   (segs & {SLOT_CAP{SEG_KEEP}}) == '0)
  `SSND_ASSERT_NOW(a_slot_bound, state == ST_DIGIT, slot < SLOT_W'(DIGIT_LIMIT))

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ssnd_pkg::*;

  typedef struct {
    logic [31:0] low;
    logic [15:0] high;
    logic        ovf;
  } display_result_t;

  // segment glyphs for hex 0..F, digit 0 in the low bits
  localparam logic [16*7-1:0] HEX_GLYPHS = {
    7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
    7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };
  localparam logic [6:0] MINUS_GLYPH = 7'h40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  cmd_t              mode = CMD_CLEAR_ALL;
  logic [2:0]        digit_position = '0;
  logic [3:0]        digit_value = '0;
  logic signed [NUM_W-1:0] number = '0;
  logic              busy;
  logic              done;
  logic [31:0]       low_displays;
  logic [15:0]       high_displays;
  logic              overflow;

  // predicted contents of all six slots, slot 0 in the low byte
  logic [8*SLOT_CAP-1:0] shown_segs = {SLOT_CAP{8'h3F}};
  display_result_t   pending_displays[$];
  int                error_count = 0;
  int                idle_pct = 0;

  seven_segment_number_display u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .digit_position(digit_position),
    .digit_value   (digit_value),
    .number        (number),
    .done          (done),
    .low_displays  (low_displays),
    .high_displays (high_displays),
    .overflow      (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [6:0] glyph_of(input logic [3:0] v);
    return HEX_GLYPHS[7*v +: 7];
  endfunction

  function automatic void light_slot(input int slot, input logic [6:0] glyph);
    if (slot < DISPLAY_COUNT && slot < SLOT_CAP) shown_segs[8*slot +: 8] |= {1'b0, glyph};
  endfunction

  function automatic display_result_t apply_command(input cmd_t m, input logic [2:0] pos,
                                                    input logic [3:0] val,
                                                    input logic [NUM_W-1:0] num);
    display_result_t r;
    logic [NUM_W-1:0] mag;
    logic             neg;
    int               slot;
    r.ovf = 1'b0;
    case (m)
      CMD_CLEAR_ALL: shown_segs = '0;
      CMD_CLEAR_DIGIT: begin
        // bit 7 of the slot survives
        if (pos < DISPLAY_COUNT && pos < SLOT_CAP) shown_segs[8*pos +: 7] = '0;
      end
      CMD_WRITE_HEX: light_slot(pos, glyph_of(val));
      default: begin
        shown_segs = '0;
        neg = num[NUM_W-1];
        mag = neg ? NUM_W'(-num) : num;
        slot = 0;
        do begin
          light_slot(slot, glyph_of(4'(mag % 10)));
          mag = mag / 10;
          slot++;
        end while (mag != 0 && slot < DIGIT_LIMIT);
        if (neg) begin
          light_slot(slot, MINUS_GLYPH);
          slot++;
        end
        r.ovf = (slot > DISPLAY_COUNT);
      end
    endcase
    r.low = shown_segs[31:0];
    r.high = shown_segs[47:32];
    return r;
  endfunction

  // call at a rising edge; returns at the edge that accepted the request
  task automatic send_request(input cmd_t m, input logic [2:0] pos, input logic [3:0] val,
                              input logic [NUM_W-1:0] num);
    // each cycle the sender stays idle with probability idle_pct
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    digit_position <= pos;
    digit_value <= val;
    number <= num;
    do @(posedge clk); while (busy);
    pending_displays.push_back(apply_command(m, pos, val, num));
  endtask

  always @(posedge clk) begin
    display_result_t want;
    if (!rst && done) begin
      if (pending_displays.size() == 0) begin
        $display("%0t: result with no request pending: low %h high %h ovf %b",
                 $time, low_displays, high_displays, overflow);
        error_count++;
      end else begin
        want = pending_displays.pop_front();
        if (low_displays !== want.low) begin
          $display("%0t: low_displays expected %h actual %h", $time, want.low, low_displays);
          error_count++;
        end
        if (high_displays !== want.high) begin
          $display("%0t: high_displays expected %h actual %h", $time, want.high,
                   high_displays);
          error_count++;
        end
        if (overflow !== want.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, want.ovf, overflow);
          error_count++;
        end
      end
    end
  end

  function automatic logic [NUM_W-1:0] pick_number();
    int digits;
    int mag;
    if ($urandom_range(7) == 0) return NUM_W'($urandom);
    digits = $urandom_range(1, 6);
    mag = $urandom_range(10 ** digits - 1, (digits == 1) ? 0 : 10 ** (digits - 1));
    return $urandom_range(1) ? NUM_W'(-mag) : NUM_W'(mag);
  endfunction

  // every hex glyph, slots 6 and 7 included, on top of the reset pattern
  task automatic test_slot_writes();
    idle_pct = 0;
    send_request(CMD_CLEAR_DIGIT, 3'd2, 4'd0, '0);
    for (int v = 0; v < 16; v++) send_request(CMD_WRITE_HEX, 3'(v % 8), 4'(v), '0);
    send_request(CMD_CLEAR_DIGIT, 3'd7, 4'd15, '0);
    send_request(CMD_CLEAR_ALL, 3'd0, 4'd0, '0);
  endtask

  // widest numbers, minus sign pushed out of range, full 21-bit extremes
  task automatic test_number_edges();
    send_request(CMD_NUMBER, 3'd0, 4'd0, NUM_W'(999999));
    send_request(CMD_NUMBER, 3'd0, 4'd0, NUM_W'(-999999));
    send_request(CMD_NUMBER, 3'd0, 4'd0, NUM_W'(-100000));
    send_request(CMD_NUMBER, 3'd0, 4'd0, NUM_W'(-99999));
    send_request(CMD_NUMBER, 3'd0, 4'd0, {1'b0, {(NUM_W-1){1'b1}}});
    send_request(CMD_NUMBER, 3'd0, 4'd0, {1'b1, {(NUM_W-1){1'b0}}});
    send_request(CMD_NUMBER, 3'd7, 4'd15, '0);
  endtask

  task automatic test_random_traffic(input int pct, input int count);
    int   roll;
    cmd_t m;
    idle_pct = pct;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 10) m = CMD_CLEAR_ALL;
      else if (roll < 35) m = CMD_CLEAR_DIGIT;
      else if (roll < 65) m = CMD_WRITE_HEX;
      else m = CMD_NUMBER;
      send_request(m, 3'($urandom_range(7)), 4'($urandom_range(15)), pick_number());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_slot_writes();
    test_number_edges();
    test_random_traffic(0, 184);
    test_random_traffic(76, 183);
    test_random_traffic(11, 183);
    start <= 1'b0;
    wait (pending_displays.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/ssnd_pkg.sv
sv/seven_segment_number_display.sv
dv/tb_top.sv
